// ===== design/gs_tri_pkg.sv =====
package gs_tri_pkg;

   localparam int DATA_W = 32;
   localparam int NODE_W = 6;
   localparam int SWEEP_W = 16;
   localparam int TOL_W = 31;
   localparam int CSR_INDEX_W = 3;

   typedef logic [NODE_W-1:0] node_index_type;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNDARY_GAIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUPLING      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERIOR_GAIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SWEEPS    = 3'd4;

   // reset values, Q16.16 where fractional
   localparam logic signed [DATA_W-1:0] BOUNDARY_GAIN_RST = 32'sd65536;
   localparam logic signed [DATA_W-1:0] COUPLING_RST      = -32'sd65536;
   localparam logic signed [DATA_W-1:0] INTERIOR_GAIN_RST = 32'sd32768;
   localparam logic [TOL_W-1:0]         TOLERANCE_RST     = 31'd1;
   localparam logic [SWEEP_W-1:0]       MAX_SWEEPS_RST    = 16'd1000;

   typedef struct packed {
      logic signed [DATA_W-1:0] boundary_gain;
      logic signed [DATA_W-1:0] coupling;
      logic signed [DATA_W-1:0] interior_gain;
      logic [TOL_W-1:0]         tolerance;
      logic [SWEEP_W-1:0]       max_sweeps;
   } cfg_type;

   typedef struct packed {
      node_index_type           node_index;
      logic signed [DATA_W-1:0] potential;
      logic                     last_node;
      logic                     converged;
      logic [SWEEP_W-1:0]       sweeps_used;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_CUR,
      ST_RD_NB,
      ST_OPA,
      ST_MUL_B,
      ST_FIX_B,
      ST_SUM,
      ST_MUL_G,
      ST_FIX_G,
      ST_WB,
      ST_OUT_RD,
      ST_OUT_LOAD
   } eng_state_type;

endpackage

// ===== design/gs_tri_store.sv =====
module gs_tri_store #(
   parameter int DEPTH = 64,
   parameter int ADDR_W = 6
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [ADDR_W-1:0]             waddr,
   input  logic [gs_tri_pkg::DATA_W-1:0] wdata,
   input  logic                          re,
   input  logic [ADDR_W-1:0]             raddr,
   output logic [gs_tri_pkg::DATA_W-1:0] rdata
);

   logic [gs_tri_pkg::DATA_W-1:0] mem [DEPTH];
   logic [gs_tri_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/gs_tri_engine.sv =====
module gs_tri_engine #(
   parameter int NODES = 64,
   parameter int FRACTION_BITS = 16,
   parameter int ADDR_W = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gs_tri_pkg::cfg_type                  cfg,
   input  logic                                 start,
   input  logic signed [gs_tri_pkg::DATA_W-1:0] surface_term,
   output logic                                 idle,
   input  logic                                 out_free,
   output logic                                 out_load,
   output gs_tri_pkg::rsp_word_type             out_word,
   output logic                                 mem_we,
   output logic [ADDR_W-1:0]                    mem_waddr,
   output logic [gs_tri_pkg::DATA_W-1:0]        mem_wdata,
   output logic                                 mem_re,
   output logic [ADDR_W-1:0]                    mem_raddr,
   input  logic [gs_tri_pkg::DATA_W-1:0]        mem_rdata
);

   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(NODES - 1);
   localparam logic signed [63:0] ROUND_BIAS = (64'sd1 <<< FRACTION_BITS) - 64'sd1;
   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   // product back to Q format, truncated toward zero and saturated
   function automatic logic signed [31:0] qfix(input logic signed [63:0] p);
      logic signed [63:0] bias;
      logic signed [63:0] q;
      bias = p[63] ? ROUND_BIAS : 64'sd0;
      q = (p + bias) >>> FRACTION_BITS;
      if (q > SAT_MAX) begin
         return 32'sh7FFF_FFFF;
      end else if (q < SAT_MIN) begin
         return 32'sh8000_0000;
      end
      return q[31:0];
   endfunction

   function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
      if (s[32] != s[31]) begin
         return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return s[31:0];
   endfunction

   gs_tri_pkg::eng_state_type state_ff, state_in;
   logic [ADDR_W-1:0]              k_ff, k_in;
   logic [gs_tri_pkg::SWEEP_W-1:0] sweep_ff, sweep_in;
   logic                           first_ff, first_in;
   logic                           conv_ff, conv_in;
   logic signed [31:0]             c_ff, c_in;
   logic signed [31:0]             old_ff, old_in;
   logic signed [31:0]             nb_ff, nb_in;
   logic signed [31:0]             prev_ff, prev_in;
   logic signed [31:0]             fix_ff, fix_in;
   logic signed [31:0]             sum_ff, sum_in;
   logic [31:0]                    largest_ff, largest_in;
   logic signed [63:0]             prod_ff;

   logic                           boundary;
   logic signed [31:0]             mul_a, mul_b;
   logic signed [31:0]             rd_masked;
   logic signed [32:0]             diff;
   logic [31:0]                    abs_diff;
   logic [31:0]                    largest_nx;
   logic [gs_tri_pkg::SWEEP_W-1:0] cap;

   assign boundary = (k_ff == '0) || (k_ff == LAST);
   // nothing is written yet during the first sweep, so the store reads as zero
   assign rd_masked = first_ff ? 32'sd0 : $signed(mem_rdata);
   assign cap = (cfg.max_sweeps == '0) ? 16'd1 : cfg.max_sweeps;

   assign diff = {fix_ff[31], fix_ff} - {old_ff[31], old_ff};
   assign abs_diff = diff[32] ? 32'(-diff) : diff[31:0];
   assign largest_nx = (abs_diff > largest_ff) ? abs_diff : largest_ff;

   // one shared multiplier for both products of a boundary node
   always_comb begin
      if (state_ff == gs_tri_pkg::ST_MUL_B) begin
         mul_a = cfg.coupling;
         mul_b = nb_ff;
      end else begin
         mul_a = boundary ? cfg.boundary_gain : cfg.interior_gain;
         mul_b = sum_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      sweep_in   = sweep_ff;
      first_in   = first_ff;
      conv_in    = conv_ff;
      c_in       = c_ff;
      old_in     = old_ff;
      nb_in      = nb_ff;
      prev_in    = prev_ff;
      fix_in     = fix_ff;
      sum_in     = sum_ff;
      largest_in = largest_ff;
      idle       = 1'b0;
      out_load   = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_raddr  = k_ff;
      mem_waddr  = k_ff;
      mem_wdata  = fix_ff;
      out_word.node_index  = gs_tri_pkg::node_index_type'(k_ff);
      out_word.potential   = mem_rdata;
      out_word.last_node   = (k_ff == LAST);
      out_word.converged   = conv_ff;
      out_word.sweeps_used = sweep_ff;

      case (state_ff)
         gs_tri_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               c_in       = surface_term;
               k_in       = '0;
               sweep_in   = 16'd1;
               first_in   = 1'b1;
               largest_in = '0;
               state_in   = gs_tri_pkg::ST_RD_CUR;
            end
         end
         gs_tri_pkg::ST_RD_CUR: begin
            mem_re   = 1'b1;
            state_in = gs_tri_pkg::ST_RD_NB;
         end
         gs_tri_pkg::ST_RD_NB: begin
            old_in    = rd_masked;
            mem_re    = (k_ff != LAST);
            mem_raddr = ADDR_W'(k_ff + 1'b1);
            state_in  = gs_tri_pkg::ST_OPA;
         end
         gs_tri_pkg::ST_OPA: begin
            // last node couples to the value just computed for its neighbor
            nb_in    = (k_ff == LAST) ? prev_ff : rd_masked;
            state_in = boundary ? gs_tri_pkg::ST_MUL_B : gs_tri_pkg::ST_SUM;
         end
         gs_tri_pkg::ST_MUL_B: begin
            state_in = gs_tri_pkg::ST_FIX_B;
         end
         gs_tri_pkg::ST_FIX_B: begin
            fix_in   = qfix(prod_ff);
            state_in = gs_tri_pkg::ST_SUM;
         end
         gs_tri_pkg::ST_SUM: begin
            if (boundary) begin
               sum_in = sat33({c_ff[31], c_ff} - {fix_ff[31], fix_ff});
            end else begin
               sum_in = sat33({prev_ff[31], prev_ff} + {nb_ff[31], nb_ff});
            end
            state_in = gs_tri_pkg::ST_MUL_G;
         end
         gs_tri_pkg::ST_MUL_G: begin
            state_in = gs_tri_pkg::ST_FIX_G;
         end
         gs_tri_pkg::ST_FIX_G: begin
            fix_in   = qfix(prod_ff);
            state_in = gs_tri_pkg::ST_WB;
         end
         gs_tri_pkg::ST_WB: begin
            mem_we     = 1'b1;
            prev_in    = fix_ff;
            largest_in = largest_nx;
            if (k_ff != LAST) begin
               k_in     = ADDR_W'(k_ff + 1'b1);
               state_in = gs_tri_pkg::ST_RD_CUR;
            end else begin
               k_in     = '0;
               first_in = 1'b0;
               if (largest_nx <= {1'b0, cfg.tolerance}) begin
                  conv_in  = 1'b1;
                  state_in = gs_tri_pkg::ST_OUT_RD;
               end else if (sweep_ff >= cap) begin
                  conv_in  = 1'b0;
                  state_in = gs_tri_pkg::ST_OUT_RD;
               end else begin
                  sweep_in   = sweep_ff + 16'd1;
                  largest_in = '0;
                  state_in   = gs_tri_pkg::ST_RD_CUR;
               end
            end
         end
         gs_tri_pkg::ST_OUT_RD: begin
            mem_re   = 1'b1;
            state_in = gs_tri_pkg::ST_OUT_LOAD;
         end
         gs_tri_pkg::ST_OUT_LOAD: begin
            if (out_free) begin
               out_load = 1'b1;
               if (k_ff == LAST) begin
                  state_in = gs_tri_pkg::ST_IDLE;
               end else begin
                  k_in     = ADDR_W'(k_ff + 1'b1);
                  state_in = gs_tri_pkg::ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = gs_tri_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gs_tri_pkg::ST_IDLE;
         k_ff       <= '0;
         sweep_ff   <= '0;
         first_ff   <= 1'b1;
         conv_ff    <= 1'b0;
         largest_ff <= '0;
      end else begin
         state_ff   <= state_in;
         k_ff       <= k_in;
         sweep_ff   <= sweep_in;
         first_ff   <= first_in;
         conv_ff    <= conv_in;
         largest_ff <= largest_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff    <= c_in;
      old_ff  <= old_in;
      nb_ff   <= nb_in;
      prev_ff <= prev_in;
      fix_ff  <= fix_in;
      sum_ff  <= sum_in;
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

endmodule

// ===== design/gauss_seidel_tridiagonal_solver_top.sv =====
// Gauss-Seidel solver for a 1-D screened Poisson profile of NODES Q16.16 nodes between two
// charged walls. Each request word carries the wall source term; the block relaxes its
// potential store in place until one sweep's largest absolute change is at most tolerance
// or max_sweeps sweeps have run (a cap of zero runs one sweep), then returns NODES response
// words in ascending node order. All node potentials sit in one single-port-read RAM, and one
// multiplier is shared by both products of a boundary node: a boundary node steps through
// RD_CUR, RD_NB, OPA, MUL_B, FIX_B, SUM, MUL_G, FIX_G and WB, and an interior node skips
// MUL_B and FIX_B, as it needs only the gain product. There is no clearing pass: reads of
// the store during the first sweep are taken as zero. A new request is taken once the last
// response word sits in the output register.
module gauss_seidel_tridiagonal_solver_top #(
   parameter int NODES = 64,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [gs_tri_pkg::DATA_W-1:0]     req_surface_term,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [gs_tri_pkg::NODE_W-1:0]            rsp_node_index,
   output logic signed [gs_tri_pkg::DATA_W-1:0]    rsp_potential,
   output logic                                     rsp_last_node,
   output logic                                     rsp_converged,
   output logic [gs_tri_pkg::SWEEP_W-1:0]           rsp_sweeps_used,
   input  logic                                     csr_write_enable,
   input  logic [gs_tri_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [gs_tri_pkg::DATA_W-1:0]            csr_write_data
);

   localparam int ADDR_W = $clog2(NODES);

   gs_tri_pkg::cfg_type      cfg_ff;
   gs_tri_pkg::rsp_word_type rsp_word_ff;
   gs_tri_pkg::rsp_word_type out_word;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     idle;
   logic                     out_free;
   logic                     out_load;
   logic                     mem_we, mem_re;
   logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
   logic [gs_tri_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boundary_gain <= gs_tri_pkg::BOUNDARY_GAIN_RST;
         cfg_ff.coupling      <= gs_tri_pkg::COUPLING_RST;
         cfg_ff.interior_gain <= gs_tri_pkg::INTERIOR_GAIN_RST;
         cfg_ff.tolerance     <= gs_tri_pkg::TOLERANCE_RST;
         cfg_ff.max_sweeps    <= gs_tri_pkg::MAX_SWEEPS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            gs_tri_pkg::CSR_BOUNDARY_GAIN: cfg_ff.boundary_gain <= csr_write_data;
            gs_tri_pkg::CSR_COUPLING:      cfg_ff.coupling      <= csr_write_data;
            gs_tri_pkg::CSR_INTERIOR_GAIN: cfg_ff.interior_gain <= csr_write_data;
            gs_tri_pkg::CSR_TOLERANCE:     cfg_ff.tolerance     <= csr_write_data[30:0];
            gs_tri_pkg::CSR_MAX_SWEEPS:    cfg_ff.max_sweeps    <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   gs_tri_store #(
      .DEPTH (NODES),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re   (mem_re),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   gs_tri_engine #(
      .NODES        (NODES),
      .FRACTION_BITS(FRACTION_BITS),
      .ADDR_W       (ADDR_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start       (req_valid & ~req_stall),
      .surface_term(req_surface_term),
      .idle        (idle),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_word    (out_word),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re      (mem_re),
      .mem_raddr   (mem_raddr),
      .mem_rdata   (mem_rdata)
   );

   assign req_stall = ~idle;

   // output register: refilled when empty or when its word is taken
   assign out_free     = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_word_ff <= out_word;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_index  = rsp_word_ff.node_index;
   assign rsp_potential   = rsp_word_ff.potential;
   assign rsp_last_node   = rsp_word_ff.last_node;
   assign rsp_converged   = rsp_word_ff.converged;
   assign rsp_sweeps_used = rsp_word_ff.sweeps_used;

endmodule
